/* rtl/core/bucket_min_max_decimator_defines.svh */
// Assertion macros for the bucket min/max decimator.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef BUCKET_MIN_MAX_DECIMATOR_DEFINES_SVH
`define BUCKET_MIN_MAX_DECIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BMMD_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define BMMD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BMMD_ASSERT(label, expr, msg)
`define BMMD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/core/bmmd_pkg.sv */
// Shared types and constants for the bucket min/max decimator.
// No dependencies.
`timescale 1ns / 1ps
package bmmd_pkg;
   localparam int FREQ_BITS   = 48;
   localparam int INT_BITS    = 32;
   localparam int SIZE_BITS   = 16;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam int FIFO_DEPTH  = 4;
   localparam int PTR_BITS    = 2;
   localparam int LEVEL_BITS  = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_BUCKET_LEN = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_BYPASS     = 1'd1;

   localparam logic [SIZE_BITS-1:0] BUCKET_LEN_RESET = 16'd2;

   typedef struct packed {
      logic [FREQ_BITS-1:0]       freq;
      logic signed [INT_BITS-1:0] intensity;
      logic                       end_of_record;
   } item_type;

   typedef struct packed {
      logic [FREQ_BITS-1:0]       freq;
      logic signed [INT_BITS-1:0] intensity;
      logic                       last_of_run;
      logic                       record_done;
   } result_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] bucket_len;
      logic                 bypass;
   } cfg_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic                  valid;
      logic                  room;
      logic [LEVEL_BITS-1:0] level;
   } fifo_status_type;
endpackage

/* rtl/core/bmmd_if.sv */
// Stream channel interfaces: point input and decimated result output.
// Depends on bmmd_pkg.
`timescale 1ns / 1ps
interface bmmd_req_if import bmmd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [FREQ_BITS-1:0]       freq;
   logic signed [INT_BITS-1:0] intensity;
   logic                       end_of_record;

   modport source (output valid, freq, intensity, end_of_record, input ready);
   modport sink (input valid, freq, intensity, end_of_record, output ready);
endinterface

interface bmmd_rsp_if import bmmd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [FREQ_BITS-1:0]       out_freq;
   logic signed [INT_BITS-1:0] out_intensity;
   logic                       last_of_run;
   logic                       record_done;

   modport source (output valid, out_freq, out_intensity, last_of_run, record_done,
                   input ready);
   modport sink (input valid, out_freq, out_intensity, last_of_run, record_done,
                 output ready);
endinterface

/* rtl/core/bucket_min_max_decimator.sv */
// Top level of the bucket min/max decimator: CSRs, bucket tracker, result queue.
// Depends on bmmd_pkg, bmmd_if, bmmd_bucket, bmmd_out_fifo and the defines header.
//
// Points arrive on req (freq, intensity, end_of_record); results leave on rsp.
// A transfer on either channel is a cycle with valid and ready both high.
// In decimate mode each bucket of bucket length points (below 2 taken as 2, or
// fewer, closed by end_of_record) yields its minimum and maximum point in stream order, or a
// single point if both are one sample. In bypass every point is passed on.
// Results of a closing transfer are registered into the result queue and reach rsp in order.
// Throughput: one point per cycle while req.ready is high; rsp gives one result
// per cycle while rsp.ready is high. The four-entry result queue holds ready
// high while two entries are free, so points keep flowing while results wait.
// When rsp stalls, the queue fills and req.ready drops until it drains.
// Reset (synchronous) empties the queue, opens an empty bucket and sets
// the bucket length to 2 and bypass to 1. CSR writes take effect at once; the
// user must make them only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "bucket_min_max_decimator_defines.svh"
module bucket_min_max_decimator import bmmd_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   bmmd_req_if.sink                 req,
   bmmd_rsp_if.source               rsp,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);
   logic [SIZE_BITS-1:0] bucket_len_ff;
   logic                 bypass_ff;
   cfg_type              cfg;
   item_type             item;
   push_type             push;
   result_type           head;
   fifo_status_type      status;
   logic                 accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_len_ff <= BUCKET_LEN_RESET;
         bypass_ff     <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_BUCKET_LEN: bucket_len_ff <= csr_data[SIZE_BITS-1:0];
            REG_BYPASS:     bypass_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg    = '{bucket_len: bucket_len_ff, bypass: bypass_ff};
   assign item   = '{freq: req.freq, intensity: req.intensity,
                     end_of_record: req.end_of_record};
   assign req.ready = status.room;
   assign accept = req.valid && status.room;

   bmmd_bucket #(.COUNT_BITS(COUNT_BITS)) u_bucket (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .cfg    (cfg),
      .push   (push)
   );

   bmmd_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (rsp.ready),
      .head      (head),
      .status    (status)
   );

   assign rsp.valid         = status.valid;
   assign rsp.out_freq      = head.freq;
   assign rsp.out_intensity = head.intensity;
   assign rsp.last_of_run   = head.last_of_run;
   assign rsp.record_done   = head.record_done;

   `BMMD_ASSERT(a_level_bound, status.level <= LEVEL_BITS'(FIFO_DEPTH), "queue overflow")
   `BMMD_ASSERT(a_valid_level, status.valid == (status.level != '0), "valid/level mismatch")
   `BMMD_ASSERT_NEXT(a_bypass_out, accept && bypass_ff, status.valid, "bypass result lost")
endmodule

/* rtl/core/bmmd_bucket.sv */
// Bucket tracker: running min/max per bucket and the results at bucket close, or each point in bypass.
// Depends on bmmd_pkg.
`timescale 1ns / 1ps
module bmmd_bucket import bmmd_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  item_type item,
   input  cfg_type  cfg,
   output push_type push
);
   localparam int SW = 33;
   localparam logic [SW-1:0] COUNT_MAX = (SW'(1) << COUNT_BITS) - SW'(1);

   logic [COUNT_BITS-1:0]      fill_count_ff, fill_count_in;
   logic signed [INT_BITS-1:0] low_value_ff, low_value_in;
   logic [FREQ_BITS-1:0]       low_freq_ff, low_freq_in;
   logic [COUNT_BITS-1:0]      low_position_ff, low_position_in;
   logic signed [INT_BITS-1:0] high_value_ff, high_value_in;
   logic [FREQ_BITS-1:0]       high_freq_ff, high_freq_in;
   logic [COUNT_BITS-1:0]      high_position_ff, high_position_in;

   logic [SW-1:0]         size_eff;
   logic [COUNT_BITS-1:0] fill_next;
   logic                  fresh, take_low, take_high, close;
   result_type            low_res, high_res;

   always_comb begin
      priority if (cfg.bucket_len < SIZE_BITS'(2)) begin
         size_eff = SW'(2);
      end else if (SW'(cfg.bucket_len) > COUNT_MAX) begin
         size_eff = COUNT_MAX;
      end else begin
         size_eff = SW'(cfg.bucket_len);
      end
   end

   always_comb begin
      fresh     = (fill_count_ff == '0);
      take_low  = fresh || ($signed(item.intensity) < low_value_ff);
      take_high = fresh || ($signed(item.intensity) > high_value_ff);
      fill_next = fill_count_ff + COUNT_BITS'(1);
      close     = (SW'(fill_next) >= size_eff) || item.end_of_record;

      low_value_in     = take_low ? item.intensity : low_value_ff;
      low_freq_in      = take_low ? item.freq : low_freq_ff;
      low_position_in  = take_low ? fill_count_ff : low_position_ff;
      high_value_in    = take_high ? item.intensity : high_value_ff;
      high_freq_in     = take_high ? item.freq : high_freq_ff;
      high_position_in = take_high ? fill_count_ff : high_position_ff;
      fill_count_in    = close ? '0 : fill_next;

      low_res  = '{freq: low_freq_in, intensity: low_value_in,
                   last_of_run: 1'b0, record_done: 1'b0};
      high_res = '{freq: high_freq_in, intensity: high_value_in,
                   last_of_run: 1'b0, record_done: 1'b0};

      push = '0;
      if (accept) begin
         if (cfg.bypass) begin
            push.count = 2'd1;
            push.first = '{freq: item.freq, intensity: item.intensity,
                           last_of_run: 1'b1, record_done: item.end_of_record};
         end else if (close) begin
            priority if (low_position_in < high_position_in) begin
               push.count  = 2'd2;
               push.first  = low_res;
               push.second = high_res;
            end else if (high_position_in < low_position_in) begin
               push.count  = 2'd2;
               push.first  = high_res;
               push.second = low_res;
            end else begin
               push.count = 2'd1;
               push.first = low_res;
            end
            if (push.count == 2'd2) begin
               push.second.last_of_run = 1'b1;
               push.second.record_done = item.end_of_record;
            end else begin
               push.first.last_of_run = 1'b1;
               push.first.record_done = item.end_of_record;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else if (accept && !cfg.bypass) begin
         fill_count_ff <= fill_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !cfg.bypass) begin
         low_value_ff     <= low_value_in;
         low_freq_ff      <= low_freq_in;
         low_position_ff  <= low_position_in;
         high_value_ff    <= high_value_in;
         high_freq_ff     <= high_freq_in;
         high_position_ff <= high_position_in;
      end
   end
endmodule

/* rtl/core/bmmd_out_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on bmmd_pkg.
`timescale 1ns / 1ps
module bmmd_out_fifo import bmmd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   input  logic            pop_ready,
   output result_type      head,
   output fifo_status_type status
);
   result_type            mem [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic                  pop;

   always_comb begin
      status.valid = (level_ff != '0);
      status.room  = (level_ff <= LEVEL_BITS'(FIFO_DEPTH - 2));
      status.level = level_ff;
      head         = mem[rd_ptr_ff];
      pop          = status.valid && pop_ready;
      wr_ptr_in    = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in    = rd_ptr_ff + PTR_BITS'(pop);
      level_in     = level_ff + LEVEL_BITS'(push.count) - LEVEL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + PTR_BITS'(1)] <= push.second;
      end
   end
endmodule
